// ===== rtl/itp_pkg.sv =====
package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int RANK_W      = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_SYNTAX = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_POP_ON_EQUAL = 1'b1;

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_MUL   = 8'h2a;
	localparam logic [7:0] CH_DIV   = 8'h2f;
	localparam logic [7:0] CH_MOD   = 8'h25;
	localparam logic [7:0] CH_POW   = 8'h5e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;

	// ordered by binding strength; operator compares rely on it
	typedef enum logic [2:0] {
		CLS_OPERAND = 3'd0,
		CLS_OPEN    = 3'd1,
		CLS_CLOSE   = 3'd2,
		CLS_SUM     = 3'd3,
		CLS_MUL     = 3'd4,
		CLS_POW     = 3'd5
	} cls_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OPND_OPND = 3'd1,
		ST_OPR_OPR   = 3'd2,
		ST_BRACKET   = 3'd3,
		ST_MANY_OPR  = 3'd4,
		ST_MANY_OPND = 3'd5,
		ST_OVERFLOW  = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_expr;
		cls_t       cls;
		logic       space;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		status_t    status;
		logic       last;
	} result_t;

	typedef struct packed {
		logic check_syntax;
		logic pop_on_equal;
	} cfg_t;

	function automatic cls_t class_of(input logic [7:0] c);
		cls_t r;
		unique case (c)
			CH_OPEN:                  r = CLS_OPEN;
			CH_CLOSE:                 r = CLS_CLOSE;
			CH_PLUS, CH_MINUS:        r = CLS_SUM;
			CH_MUL, CH_DIV, CH_MOD:   r = CLS_MUL;
			CH_POW:                   r = CLS_POW;
			default:                  r = CLS_OPERAND;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/itp_in_if.sv =====
interface itp_in_if import itp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_expr;

	modport source (output valid, output in_char, output end_of_expr, input ready);
	modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

// ===== rtl/itp_out_if.sv =====
interface itp_out_if import itp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       has_char;
	logic [2:0] status;
	logic       last;

	modport source (output valid, output out_char, output has_char, output status,
		output last, input ready);
	modport sink (input valid, input out_char, input has_char, input status,
		input last, output ready);
endinterface

// ===== rtl/itp_cfg_if.sv =====
interface itp_cfg_if import itp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic                 data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/infix_to_postfix_converter.sv =====
// Infix to postfix converter, shunting-yard style.
// expr: one ASCII character per item (in_char), or an end item (end_of_expr)
//   that drains the operator stack and closes the run with a status result.
// postfix: result items; out_char/has_char for an emitted character, status
//   on the closing or error result, last on the final result of each item.
// cfg: register writes, index 0 check_syntax, index 1 pop_on_equal; always ready.
// Back-end steps: operands, spaces, open brackets and ignored items are handled
//   as they are taken. An operator is taken, then pushed; a close bracket is
//   taken, drops the open bracket, refills the top, then is released; an end
//   item is taken, then closes, or closes at once after an error. Each operator
//   popped off the stack is emitted, then the top register is refilled from the
//   stack RAM's registered read; a pop followed by an error or the end status
//   adds a release step; an error ends an item early.
// The front end classifies items into a two-entry queue, so input keeps
//   flowing while the back end pops or the receiver stalls, until the queue fills.
// Reset: run state cleared, check_syntax on, pop_on_equal off; stack RAM holds
//   garbage but only entries below the stack pointer are used.
// A stalled receiver holds the output register; the back end waits for it.
module infix_to_postfix_converter import itp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	itp_in_if.sink     expr,
	itp_out_if.source  postfix,
	itp_cfg_if.sink    cfg
);
	cfg_t  cfg_q;
	item_t q_item;
	logic  q_valid;
	logic  q_ready;

	// configuration registers; the user must write them only while idle, the block itself does not enforce it
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_syntax <= 1'b1;
			cfg_q.pop_on_equal <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_CHECK_SYNTAX: cfg_q.check_syntax <= cfg.data;
				CFG_POP_ON_EQUAL: cfg_q.pop_on_equal <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify
	itp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.expr   (expr),
		.q_item (q_item),
		.q_valid(q_valid),
		.q_ready(q_ready)
	);

	// back: operator stack, emit sequencing, output register
	itp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (q_item),
		.item_valid(q_valid),
		.item_ready(q_ready),
		.postfix   (postfix)
	);
endmodule

// ===== rtl/itp_ram.sv =====
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/itp_front.sv =====
module itp_front import itp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	itp_in_if.sink       expr,
	output item_t        q_item,
	output logic         q_valid,
	input  logic         q_ready
);
	// two-entry queue of classified items
	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	item_t      cls_item;
	logic       push;
	logic       pop;

	always_comb begin
		cls_item.ch          = expr.in_char;
		cls_item.end_of_expr = expr.end_of_expr;
		cls_item.cls         = class_of(expr.in_char);
		cls_item.space       = (expr.in_char == CH_SPACE) ||
			((expr.in_char >= CH_TAB) && (expr.in_char <= CH_CR));
	end

	assign expr.ready = (fill_q != 2'd2);
	assign q_valid    = (fill_q != 2'd0);
	assign q_item     = ent_q[rd_ptr_q];
	assign push       = expr.valid && expr.ready;
	assign pop        = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/itp_back.sv =====
module itp_back import itp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  item_t        item,
	input  logic         item_valid,
	output logic         item_ready,
	itp_out_if.source    postfix
);
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOOP,
		BK_REFILL,
		BK_FIN
	} bk_state_t;

	typedef enum logic [1:0] {
		KIND_CLOSE,
		KIND_OP,
		KIND_END
	} kind_t;

	typedef struct packed {
		logic       deq;
		logic       emit;
		logic       fin;
		logic       err;
		logic       clr;
		logic       push;
		logic       pop;
		logic       drop_open;
		logic       rank_inc;
		logic       set_prev;
		logic       load_cur;
		logic       go_loop;
		logic       go_refill;
		logic       done;
		logic [7:0] res_char;
		logic       res_has;
		status_t    res_status;
		logic [7:0] push_char;
		cls_t       push_cls;
	} act_t;

	bk_state_t         state_q, state_d;
	act_t              act;

	logic [CNT_W-1:0]  cnt_q;
	logic [RANK_W-1:0] rank_q;
	logic [7:0]        top_q;
	cls_t              top_cls_q;
	cls_t              prev_q;
	logic              hold_q;
	status_t           code_q;
	logic              nonempty_q;
	item_t             cur_q;
	kind_t             kind_q;
	logic              done_q;

	result_t           out_q;
	logic              out_v_q;
	result_t           pend_q;
	logic              pend_v_q;
	result_t           new_res;

	logic              out_free;
	logic              full;
	logic              low_rank;
	logic              op_go;
	logic [7:0]        rd_data;
	logic [IDX_W-1:0]  rd_addr;

	assign out_free = !out_v_q || postfix.ready;
	assign full     = (cnt_q == CNT_W'(STACK_DEPTH));
	assign low_rank = (rank_q < RANK_W'(2));
	assign op_go    = cfg.pop_on_equal ? (cur_q.cls <= top_cls_q) : (cur_q.cls < top_cls_q);
	// entry below the top; its registered read is valid in the cycle after a pop
	assign rd_addr  = IDX_W'(cnt_q - CNT_W'(2));

	itp_ram #(
		.WIDTH(8),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (act.push),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata(act.push_char),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// decision for this cycle
	always_comb begin
		logic    want_pop;
		logic    fail;
		status_t code;
		want_pop = 1'b0;
		fail     = 1'b0;
		code     = ST_OK;
		act      = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (item_valid && out_free) begin
					act.deq = 1'b1;
					if (item.end_of_expr) begin
						if (hold_q) begin
							act.emit       = 1'b1;
							act.res_status = code_q;
							act.fin        = 1'b1;
							act.clr        = 1'b1;
						end else begin
							act.load_cur = 1'b1;
							act.go_loop  = 1'b1;
						end
					end else if (hold_q || (item.cls == CLS_OPERAND && item.space)) begin
						act.fin = 1'b1;
					end else begin
						if (cfg.check_syntax && item.cls != CLS_OPEN &&
							item.cls != CLS_CLOSE) begin
							if (prev_q == CLS_OPERAND && item.cls == CLS_OPERAND) begin
								fail = 1'b1;
								code = ST_OPND_OPND;
							end else if (prev_q != CLS_OPERAND && item.cls != CLS_OPERAND) begin
								fail = 1'b1;
								code = ST_OPR_OPR;
							end else begin
								act.set_prev = 1'b1;
							end
						end
						if (!fail) begin
							priority case (item.cls)
								CLS_OPERAND: begin
									act.emit     = 1'b1;
									act.res_char = item.ch;
									act.res_has  = 1'b1;
									act.fin      = 1'b1;
									act.rank_inc = 1'b1;
								end
								CLS_OPEN: begin
									if (full) begin
										fail = 1'b1;
										code = ST_OVERFLOW;
									end else begin
										act.push      = 1'b1;
										act.push_char = item.ch;
										act.push_cls  = item.cls;
										act.fin       = 1'b1;
									end
								end
								default: begin
									act.load_cur = 1'b1;
									act.go_loop  = 1'b1;
								end
							endcase
						end
						if (fail) begin
							act.emit       = 1'b1;
							act.res_status = code;
							act.fin        = 1'b1;
							act.err        = 1'b1;
						end
					end
				end
			end
			BK_LOOP: begin
				if (out_free) begin
					unique case (kind_q)
						KIND_CLOSE: begin
							if (cnt_q == '0) begin
								fail = 1'b1;
								code = ST_BRACKET;
							end else if (top_cls_q == CLS_OPEN) begin
								act.drop_open = 1'b1;
								act.go_refill = 1'b1;
								act.done      = 1'b1;
							end else begin
								want_pop = 1'b1;
							end
						end
						KIND_OP: begin
							if (cnt_q != '0 && op_go) begin
								want_pop = 1'b1;
							end else if (full) begin
								fail = 1'b1;
								code = ST_OVERFLOW;
							end else begin
								act.push      = 1'b1;
								act.push_char = cur_q.ch;
								act.push_cls  = cur_q.cls;
								act.fin       = 1'b1;
							end
						end
						default: begin
							// end item: drain, then close with a status result
							if (cnt_q != '0) begin
								if (top_cls_q == CLS_OPEN) begin
									fail = 1'b1;
									code = ST_BRACKET;
								end else begin
									want_pop = 1'b1;
								end
							end else begin
								fail = 1'b1;
								code = (nonempty_q && rank_q > RANK_W'(1)) ? ST_MANY_OPND : ST_OK;
							end
						end
					endcase
					if (want_pop) begin
						if (low_rank) begin
							fail = 1'b1;
							code = ST_MANY_OPR;
						end else begin
							act.pop       = 1'b1;
							act.emit      = 1'b1;
							act.res_char  = top_q;
							act.res_has   = 1'b1;
							act.go_refill = 1'b1;
						end
					end
					if (fail) begin
						act.emit       = 1'b1;
						act.res_status = code;
						act.fin        = 1'b1;
						act.err        = (kind_q != KIND_END);
						act.clr        = (kind_q == KIND_END);
					end
				end
			end
			BK_FIN: begin
				act.fin = out_free;
			end
			default: begin
				// top refill from the stack memory, no action
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (act.go_loop) begin
					state_d = BK_LOOP;
				end
			end
			BK_LOOP: begin
				if (act.go_refill) begin
					state_d = BK_REFILL;
				end else if (act.emit && act.fin && pend_v_q) begin
					state_d = BK_FIN;
				end else if (act.fin) begin
					state_d = BK_IDLE;
				end
			end
			BK_REFILL: begin
				state_d = done_q ? BK_FIN : BK_LOOP;
			end
			default: begin
				if (act.fin) begin
					state_d = BK_IDLE;
				end
			end
		endcase
	end

	assign item_ready = act.deq;

	assign new_res = '{out_char: act.res_char, has_char: act.res_has,
		status: act.res_status, last: 1'b0};

	// payload registers
	always_ff @(posedge clk) begin
		if (act.load_cur) begin
			cur_q <= item;
			if (item.end_of_expr) begin
				kind_q <= KIND_END;
			end else if (item.cls == CLS_CLOSE) begin
				kind_q <= KIND_CLOSE;
			end else begin
				kind_q <= KIND_OP;
			end
		end
		if (act.push) begin
			top_q     <= act.push_char;
			top_cls_q <= act.push_cls;
		end else if (state_q == BK_REFILL) begin
			top_q     <= rd_data;
			top_cls_q <= class_of(rd_data);
		end
		if (act.emit && pend_v_q) begin
			out_q  <= '{out_char: pend_q.out_char, has_char: pend_q.has_char,
				status: pend_q.status, last: 1'b0};
			pend_q <= new_res;
		end else if (act.emit && act.fin) begin
			out_q <= '{out_char: act.res_char, has_char: act.res_has,
				status: act.res_status, last: 1'b1};
		end else if (act.emit) begin
			pend_q <= new_res;
		end else if (act.fin && pend_v_q) begin
			out_q <= '{out_char: pend_q.out_char, has_char: pend_q.has_char,
				status: pend_q.status, last: 1'b1};
		end
	end

	// control and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			cnt_q      <= '0;
			rank_q     <= '0;
			prev_q     <= CLS_SUM;
			hold_q     <= 1'b0;
			code_q     <= ST_OK;
			nonempty_q <= 1'b0;
			done_q     <= 1'b0;
			out_v_q    <= 1'b0;
			pend_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (act.load_cur) begin
				done_q <= 1'b0;
			end else if (act.done) begin
				done_q <= 1'b1;
			end
			if (act.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (act.pop || act.drop_open) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (act.pop) begin
				rank_q <= rank_q - RANK_W'(1);
			end else if (act.rank_inc && rank_q != '1) begin
				rank_q <= rank_q + RANK_W'(1);
			end
			if (act.pop || act.rank_inc) begin
				nonempty_q <= 1'b1;
			end
			if (act.set_prev) begin
				prev_q <= item.cls;
			end
			if (act.err) begin
				hold_q <= 1'b1;
				code_q <= act.res_status;
			end
			if (act.clr) begin
				cnt_q      <= '0;
				rank_q     <= '0;
				prev_q     <= CLS_SUM;
				hold_q     <= 1'b0;
				code_q     <= ST_OK;
				nonempty_q <= 1'b0;
			end
			// output register and held result
			if (act.emit && pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (act.emit && act.fin) begin
				out_v_q <= 1'b1;
			end else if (act.emit) begin
				pend_v_q <= 1'b1;
				if (postfix.ready) begin
					out_v_q <= 1'b0;
				end
			end else if (act.fin && pend_v_q) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (postfix.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign postfix.valid    = out_v_q;
	assign postfix.out_char = out_q.out_char;
	assign postfix.has_char = out_q.has_char;
	assign postfix.status   = out_q.status;
	assign postfix.last     = out_q.last;
endmodule

// ===== tb/infix_to_postfix_converter_checker.sv =====
module infix_to_postfix_converter_checker import itp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	itp_in_if           expr,
	itp_out_if          postfix,
	itp_cfg_if          cfg,
	output int unsigned errors,
	output int unsigned waiting,
	output int unsigned checked,
	output logic [6:0]  status_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [RANK_W-1:0] RANK_MAX = '1;
	localparam int unsigned PRINT_CAP = 40;

	// shadow of the conversion state
	logic [7:0]        opstk [STACK_DEPTH];
	int unsigned       depth;
	logic [RANK_W-1:0] rank;
	cls_t              prev_cls;
	logic              held;
	status_t           held_code;
	logic              emitted;
	cfg_t              regs;

	result_t           batch[$];
	result_t           postfix_due[$];

	function automatic cls_t char_kind(input logic [7:0] c);
		case (c)
			CH_OPEN:                return CLS_OPEN;
			CH_CLOSE:               return CLS_CLOSE;
			CH_PLUS, CH_MINUS:      return CLS_SUM;
			CH_MUL, CH_DIV, CH_MOD: return CLS_MUL;
			CH_POW:                 return CLS_POW;
			default:                return CLS_OPERAND;
		endcase
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("%0t ns postfix mismatch: %s", $realtime, msg);
	endtask

	task automatic add_result(input logic [7:0] ch, input logic has, input status_t st);
		result_t r;
		r.out_char = ch;
		r.has_char = has;
		r.status   = st;
		r.last     = 1'b0;
		batch.push_back(r);
	endtask

	task automatic raise_error(input status_t code);
		held      = 1'b1;
		held_code = code;
		add_result(8'h00, 1'b0, code);
	endtask

	task automatic pop_operator(output logic ok);
		if (rank < 2) begin
			raise_error(ST_MANY_OPR);
			ok = 1'b0;
		end else begin
			rank--;
			depth--;
			add_result(opstk[depth], 1'b1, ST_OK);
			emitted = 1'b1;
			ok      = 1'b1;
		end
	endtask

	task automatic clear_run();
		depth     = 0;
		rank      = '0;
		prev_cls  = CLS_SUM;
		held      = 1'b0;
		held_code = ST_OK;
		emitted   = 1'b0;
	endtask

	task automatic convert_char(input logic [7:0] c);
		cls_t k;
		logic ok;
		logic go;
		k = char_kind(c);
		if (k == CLS_OPERAND && is_blank(c))
			return;
		// alternation check skips brackets
		if (regs.check_syntax && k != CLS_OPEN && k != CLS_CLOSE) begin
			if (prev_cls == CLS_OPERAND) begin
				if (k == CLS_OPERAND) begin
					raise_error(ST_OPND_OPND);
					return;
				end
			end else if (k != CLS_OPERAND) begin
				raise_error(ST_OPR_OPR);
				return;
			end
			prev_cls = k;
		end
		case (k)
			CLS_OPERAND: begin
				add_result(c, 1'b1, ST_OK);
				emitted = 1'b1;
				if (rank != RANK_MAX)
					rank++;
			end
			CLS_OPEN: begin
				if (depth >= STACK_DEPTH) begin
					raise_error(ST_OVERFLOW);
					return;
				end
				opstk[depth] = c;
				depth++;
			end
			CLS_CLOSE: begin
				forever begin
					if (depth == 0) begin
						raise_error(ST_BRACKET);
						return;
					end
					if (char_kind(opstk[depth-1]) == CLS_OPEN)
						break;
					pop_operator(ok);
					if (!ok)
						return;
				end
				depth--;
			end
			default: begin
				while (depth > 0) begin
					go = regs.pop_on_equal ? (k <= char_kind(opstk[depth-1]))
					                       : (k < char_kind(opstk[depth-1]));
					if (!go)
						break;
					pop_operator(ok);
					if (!ok)
						return;
				end
				if (depth >= STACK_DEPTH) begin
					raise_error(ST_OVERFLOW);
					return;
				end
				opstk[depth] = c;
				depth++;
			end
		endcase
	endtask

	task automatic close_expr();
		logic ok;
		if (held) begin
			add_result(8'h00, 1'b0, held_code);
		end else begin
			while (depth > 0) begin
				if (char_kind(opstk[depth-1]) == CLS_OPEN) begin
					raise_error(ST_BRACKET);
					break;
				end
				pop_operator(ok);
				if (!ok)
					break;
			end
			if (!held) begin
				if (emitted && rank > 1)
					raise_error(ST_MANY_OPND);
				else
					add_result(8'h00, 1'b0, ST_OK);
			end
		end
		clear_run();
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_run();
			regs.check_syntax = 1'b1;
			regs.pop_on_equal = 1'b0;
			postfix_due.delete();
			errors      = 0;
			waiting     = 0;
			checked     = 0;
			status_seen = '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_CHECK_SYNTAX)
					regs.check_syntax = cfg.data;
				else if (cfg.index == CFG_POP_ON_EQUAL)
					regs.pop_on_equal = cfg.data;
			end
			if (expr.valid && expr.ready) begin
				batch.delete();
				if (expr.end_of_expr)
					close_expr();
				else if (!held)
					convert_char(expr.in_char);
				if (batch.size() > 0)
					batch[batch.size()-1].last = 1'b1;
				foreach (batch[i])
					postfix_due.push_back(batch[i]);
			end
			if (postfix.valid && postfix.ready) begin
				checked++;
				if (postfix.has_char === 1'b0 && postfix.status < 3'd7)
					status_seen[postfix.status] = 1'b1;
				if (postfix_due.size() == 0) begin
					report($sformatf("result char %02h has %b status %0d last %b, none expected",
						postfix.out_char, postfix.has_char, postfix.status, postfix.last));
				end else begin
					want = postfix_due.pop_front();
					if (postfix.out_char !== want.out_char)
						report($sformatf("out_char %02h, expected %02h",
							postfix.out_char, want.out_char));
					if (postfix.has_char !== want.has_char)
						report($sformatf("has_char %b, expected %b",
							postfix.has_char, want.has_char));
					if (postfix.status !== want.status)
						report($sformatf("status %0d, expected %0d",
							postfix.status, want.status));
					if (postfix.last !== want.last)
						report($sformatf("last %b, expected %b", postfix.last, want.last));
				end
			end
			waiting = postfix_due.size();
		end
	end

endmodule

// ===== tb/infix_to_postfix_converter_test.sv =====
module infix_to_postfix_converter_test import itp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RESET_CYCLES   = 8;
	localparam int unsigned CYCLE_LIMIT    = 1_000_000;
	// each pop is emitted and then refilled, and the front queue holds two items,
	// so SETTLE_CYCLES covers any silent work still in flight
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned SQUEEZE_CYCLES = 150;
	localparam int unsigned RANDOM_PER_SET = 4;
	localparam int unsigned CHAIN_LEN      = 6;

	localparam logic [7:0] OPERATORS [6] = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_MOD, CH_POW};
	// register settings visited after the directed part; extremes included
	localparam cfg_t SETTINGS_LIST [4] = '{2'b11, 2'b00, 2'b01, 2'b10};

	typedef logic [7:0] char_q_t[$];

	logic clk;
	logic arst_n;

	itp_in_if  expr_if ();
	itp_out_if postfix_if ();
	itp_cfg_if cfg_if ();

	int unsigned mismatches;
	int unsigned due_count;
	int unsigned results_checked;
	logic [6:0]  statuses_seen;

	int unsigned items_sent;
	int unsigned exprs_sent;
	int unsigned settings_used;
	int unsigned cycle_count;
	int unsigned squeeze_req;
	int unsigned squeeze_done;
	logic        no_gaps;

	infix_to_postfix_converter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.expr    (expr_if),
		.postfix (postfix_if),
		.cfg     (cfg_if)
	);

	// watches all three channels, predicts the postfix stream and compares
	infix_to_postfix_converter_checker postfix_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.expr        (expr_if),
		.postfix     (postfix_if),
		.cfg         (cfg_if),
		.errors      (mismatches),
		.waiting     (due_count),
		.checked     (results_checked),
		.status_seen (statuses_seen)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// hard stop in case the block hangs or drops results
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count, due_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Sender gap: mostly back to back, some short pauses, a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	// Operand: letters and digits mostly, now and then any byte the block
	// treats as an operand (high half included).
	function automatic logic [7:0] rand_operand();
		logic [7:0] c;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 8'("a" + $urandom_range(0, 25));
		if (r < 80)
			return 8'("0" + $urandom_range(0, 9));
		do
			c = 8'($urandom_range(0, 255));
		while (class_of(c) != CLS_OPERAND || c == CH_SPACE || c inside {[8'd9:8'd13]});
		return c;
	endfunction

	function automatic logic [7:0] rand_blank();
		int unsigned r;
		r = $urandom_range(0, 5);
		return (r == 0) ? CH_SPACE : 8'(r + 8);
	endfunction

	// Offer one item; returns at the rising edge that takes it.
	// valid is touched only at falling edges, once per edge.
	task automatic send_item(input logic [7:0] c, input logic e);
		int unsigned idle;
		idle = pick_gap();
		@(negedge clk);
		if (idle != 0) begin
			expr_if.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		expr_if.valid       <= 1'b1;
		expr_if.in_char     <= c;
		expr_if.end_of_expr <= e;
		do
			@(posedge clk);
		while (!expr_if.ready);
		items_sent++;
	endtask

	// One expression: its characters, then an end item with a random
	// (ignored) byte riding along.
	task automatic run_text(input char_q_t text);
		foreach (text[i])
			send_item(text[i], 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
		exprs_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Quiet the input, wait out every expected result, then let the
	// back end finish any item that produces nothing.
	task automatic wait_idle();
		@(negedge clk);
		expr_if.valid <= 1'b0;
		wait (due_count == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed infix with random content; about one in five
	// gets a character replaced, dropped or inserted.
	task automatic random_expr();
		char_q_t text;
		int unsigned terms;
		int unsigned open;
		int unsigned k;
		terms = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 12);
		open  = 0;
		for (int unsigned i = 0; i < terms; i++) begin
			while (open < 8 && $urandom_range(0, 3) == 0) begin
				text.push_back(CH_OPEN);
				open++;
			end
			text.push_back(rand_operand());
			while (open > 0 && $urandom_range(0, 2) == 0) begin
				text.push_back(CH_CLOSE);
				open--;
			end
			if (i + 1 < terms)
				text.push_back(OPERATORS[$urandom_range(0, 5)]);
			if ($urandom_range(0, 9) == 0)
				text.push_back(rand_blank());
		end
		while (open > 0) begin
			text.push_back(CH_CLOSE);
			open--;
		end
		if ($urandom_range(0, 99) < 20) begin
			k = $urandom_range(0, text.size() - 1);
			case ($urandom_range(0, 2))
				0:       text[k] = 8'($urandom_range(0, 255));
				1:       text.delete(k);
				default: text.insert(k, 8'($urandom_range(0, 255)));
			endcase
		end
		run_text(text);
	endtask

	// raw bytes, no structure at all
	task automatic random_noise();
		char_q_t text;
		repeat ($urandom_range(1, 6))
			text.push_back(8'($urandom_range(0, 255)));
		run_text(text);
	endtask

	// Receiver: ready runs broken by stalls, mostly short, a few long.
	// On request it holds off for a long stretch so the block backs up.
	initial begin
		int unsigned run_left;
		int unsigned stall_left;
		int unsigned r;
		run_left   = 0;
		stall_left = 0;
		postfix_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (squeeze_req != squeeze_done) begin
				postfix_if.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
				squeeze_done++;
				postfix_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				postfix_if.ready <= 1'b0;
				stall_left--;
			end else if (run_left > 0) begin
				postfix_if.ready <= 1'b1;
				run_left--;
			end else begin
				run_left = $urandom_range(1, 60);
				r = $urandom_range(0, 99);
				if (r < 50)
					stall_left = 0;
				else if (r < 88)
					stall_left = $urandom_range(1, 3);
				else
					stall_left = $urandom_range(10, 30);
				postfix_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		char_q_t text;
		int unsigned target;
		arst_n              = 1'b0;
		expr_if.valid       = 1'b0;
		expr_if.in_char     = 8'h00;
		expr_if.end_of_expr = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.index        = CFG_CHECK_SYNTAX;
		cfg_if.data         = 1'b0;
		items_sent    = 0;
		exprs_sent    = 0;
		settings_used = 1;
		cycle_count   = 0;
		squeeze_req   = 0;
		squeeze_done  = 0;
		no_gaps       = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings (syntax check on, strict precedence).
		// Every operator, brackets, byte extremes as operands, whitespace.
		run_text('{CH_OPEN, 8'h00, CH_MINUS, 8'hFF, CH_CLOSE, CH_MUL, CH_TAB, "q", CH_MOD,
			"r", CH_POW, "s", CH_DIV, CH_CR, "t", CH_PLUS, "u"});
		run_text('{CH_DIV});                  // leading operator
		run_text('{CH_CLOSE});                // close with nothing open
		run_text('{CH_OPEN, "k"});            // bracket still open at the end
		run_text('{"m", "n", CH_POW});        // operand after operand, rest ignored

		foreach (SETTINGS_LIST[p]) begin
			wait_idle();
			write_reg(CFG_CHECK_SYNTAX, SETTINGS_LIST[p].check_syntax);
			write_reg(CFG_POP_ON_EQUAL, SETTINGS_LIST[p].pop_on_equal);
			settings_used++;

			if (SETTINGS_LIST[p].check_syntax && SETTINGS_LIST[p].pop_on_equal) begin
				// 33 open brackets: the last push overflows the stack
				text.delete();
				repeat (STACK_DEPTH + 1)
					text.push_back(CH_OPEN);
				run_text(text);
			end

			if (!SETTINGS_LIST[p].check_syntax && !SETTINGS_LIST[p].pop_on_equal) begin
				run_text('{"u", "v"});            // too many operands
				run_text('{CH_PLUS, "w"});        // operator pop with rank below two

				// a^b^c...: right-assoc chain stacks every operator, end drains them.
				// The receiver holds off meanwhile and the sender never pauses.
				text.delete();
				for (int unsigned i = 0; i < CHAIN_LEN; i++) begin
					text.push_back(8'("a" + i % 26));
					if (i + 1 < CHAIN_LEN)
						text.push_back(CH_POW);
				end
				squeeze_req++;
				no_gaps = 1'b1;
				run_text(text);
				no_gaps = 1'b0;
			end

			// random part for this setting; some expressions run gap-free
			target = items_sent + RANDOM_PER_SET;
			while (items_sent < target) begin
				no_gaps = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 99) < 85)
					random_expr();
				else
					random_noise();
			end
			no_gaps = 1'b0;
		end

		wait_idle();
		$display("Sent %0d items in %0d expressions over %0d register settings; %0d results checked.",
			items_sent, exprs_sent, settings_used, results_checked);
		$display("Status codes seen on closing results (bit n = code n): %b", statuses_seen);
		if (mismatches == 0 && due_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/itp_pkg.sv
rtl/itp_in_if.sv
rtl/itp_out_if.sv
rtl/itp_cfg_if.sv
rtl/itp_ram.sv
rtl/itp_front.sv
rtl/itp_back.sv
rtl/infix_to_postfix_converter.sv
tb/infix_to_postfix_converter_checker.sv
tb/infix_to_postfix_converter_test.sv
